// ----- design/mbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mbsp_pkg
// Types and constants shared by the MIDI byte stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

	localparam int unsigned BYTE_W = 8;

	// byte codes
	localparam logic [BYTE_W-1:0] STATUS_MIN  = 8'h80;
	localparam logic [BYTE_W-1:0] STATUS_MAX  = 8'hEF;
	localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
	localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;

	// opcode nibbles of the two-byte channel messages
	localparam logic [3:0] OP_PROGRAM  = 4'hC;
	localparam logic [3:0] OP_PRESSURE = 4'hD;

	// result kinds
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_SYSEX   = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] midi_byte;
		logic              end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic              has;
		logic              kind;
		logic [BYTE_W-1:0] status_byte;
		logic [BYTE_W-1:0] first_data;
		logic [BYTE_W-1:0] second_data;
		logic [BYTE_W-1:0] sysex_byte;
		logic              chunk_last;
	} result_t;

endpackage

`default_nettype wire

// ----- design/mbsp_stream_if.sv -----
// ----------------------------------------------------------------------------
// mbsp_in_if / mbsp_out_if
// Valid/ready channels for received bytes and parsed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbsp_in_if;
	logic                        valid;
	logic                        ready;
	logic [mbsp_pkg::BYTE_W-1:0] midi_byte;
	logic                        end_of_buffer;

	modport source (output valid, output midi_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input midi_byte, input end_of_buffer, output ready);
endinterface

interface mbsp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [mbsp_pkg::BYTE_W-1:0] status_byte;
	logic [mbsp_pkg::BYTE_W-1:0] first_data;
	logic [mbsp_pkg::BYTE_W-1:0] second_data;
	logic [mbsp_pkg::BYTE_W-1:0] sysex_byte;
	logic                        chunk_last;

	modport source (output valid, output kind, output status_byte, output first_data,
		output second_data, output sysex_byte, output chunk_last, input ready);
	modport sink   (input valid, input kind, input status_byte, input first_data,
		input second_data, input sysex_byte, input chunk_last, output ready);
endinterface

`default_nettype wire

// ----- design/midi_byte_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// Splits a received MIDI byte stream into channel messages and sysex bytes.
// ----------------------------------------------------------------------------
// Usage:
//  in_word  : one received byte per word, end_of_buffer set on the buffer's
//             last byte.
//  out_word : one word per finished channel message (kind 0, status and two
//             data bytes, second zero for program change / channel pressure)
//             or per forwarded sysex byte (kind 1, chunk_last on 0xF7 or on
//             the buffer end).
//  Throughput: one input word per cycle while out_word is not stalled,
//  including words that give no result. The decode between the input
//  register and the result register is combinational.
//  Path: a taken word is held in the input register, then its result is
//  loaded into the result register that drives out_word.
//  Reset (arst_n low): parser idle, both registers empty, held bytes zero.
//  Stall: while out_word.ready is low and a result is waiting, words that
//  produce no result still pass; the first one that does waits in the input
//  register and in_word.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_stream_parser_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mbsp_in_if.sink    in_word,
	mbsp_out_if.source out_word
);

	logic               valid_s1;
	mbsp_pkg::in_word_t word_s1;
	mbsp_pkg::result_t  res;
	logic               can_load;
	logic               advance;

	// the held word moves on when its result (if any) has room
	assign advance = valid_s1 && (!res.has || can_load);

	mbsp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.take     (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	mbsp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.step    (advance),
		.res     (res)
	);

	mbsp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.load     (advance && res.has),
		.can_load (can_load),
		.out_word (out_word)
	);

	// channel results never carry sysex fields
	a_channel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_word.valid && out_word.kind == mbsp_pkg::KIND_CHANNEL |->
		out_word.sysex_byte == '0 && !out_word.chunk_last)
		else $error("channel result carries sysex fields");

endmodule

`default_nettype wire

// ----- design/mbsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// mbsp_in_stage
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mbsp_in_if.sink                 in_word,
	input  wire logic               take,
	output logic                    valid_s1,
	output mbsp_pkg::in_word_t      word_s1
);

	assign in_word.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_word.valid && in_word.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_word.valid && in_word.ready) begin
			word_s1.midi_byte     <= in_word.midi_byte;
			word_s1.end_of_buffer <= in_word.end_of_buffer;
		end
	end

endmodule

`default_nettype wire

// ----- design/mbsp_parser.sv -----
// ----------------------------------------------------------------------------
// mbsp_parser
// Message state machine: decodes the held word against the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mbsp_pkg::in_word_t word_s1,
	input  wire logic               step,
	output mbsp_pkg::result_t       res
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_DATA1,
		MODE_DATA2,
		MODE_SYSEX
	} mode_t;

	mode_t                       mode_q, mode_d;
	logic [mbsp_pkg::BYTE_W-1:0] held_status_q, held_first_q;
	logic [mbsp_pkg::BYTE_W-1:0] b;
	logic                        eob;
	logic                        two_byte;
	logic                        is_status;

	assign b         = word_s1.midi_byte;
	assign eob       = word_s1.end_of_buffer;
	assign two_byte  = (held_status_q[7:4] == mbsp_pkg::OP_PROGRAM) ||
		(held_status_q[7:4] == mbsp_pkg::OP_PRESSURE);
	assign is_status = (b >= mbsp_pkg::STATUS_MIN) && (b <= mbsp_pkg::STATUS_MAX);

	always_comb begin
		res    = '0;
		mode_d = mode_q;
		unique case (mode_q)
			MODE_IDLE: begin
				if (is_status) begin
					mode_d = MODE_DATA1;
				end else if (b == mbsp_pkg::SYSEX_START) begin
					res.has        = 1'b1;
					res.kind       = mbsp_pkg::KIND_SYSEX;
					res.sysex_byte = b;
					res.chunk_last = eob;
					mode_d         = MODE_SYSEX;
				end
			end
			MODE_DATA1: begin
				if (two_byte) begin
					res.has         = 1'b1;
					res.kind        = mbsp_pkg::KIND_CHANNEL;
					res.status_byte = held_status_q;
					res.first_data  = b;
					mode_d          = MODE_IDLE;
				end else begin
					mode_d = MODE_DATA2;
				end
			end
			MODE_DATA2: begin
				res.has         = 1'b1;
				res.kind        = mbsp_pkg::KIND_CHANNEL;
				res.status_byte = held_status_q;
				res.first_data  = held_first_q;
				res.second_data = b;
				mode_d          = MODE_IDLE;
			end
			MODE_SYSEX: begin
				res.has        = 1'b1;
				res.kind       = mbsp_pkg::KIND_SYSEX;
				res.sysex_byte = b;
				res.chunk_last = (b == mbsp_pkg::SYSEX_END) || eob;
				if (b == mbsp_pkg::SYSEX_END) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
		// every buffer end leaves the parser idle
		if (eob) begin
			mode_d = MODE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			held_status_q <= '0;
			held_first_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			if (mode_q == MODE_IDLE && is_status) begin
				held_status_q <= b;
			end
			if (mode_q == MODE_DATA1 && !two_byte) begin
				held_first_q <= b;
			end
		end
	end

	a_eob_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && eob |=> mode_q == MODE_IDLE)
		else $error("parser not idle after buffer end");

	a_data2_emits: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == MODE_DATA2 |-> res.has && res.kind == mbsp_pkg::KIND_CHANNEL)
		else $error("three-byte message not emitted");

endmodule

`default_nettype wire

// ----- design/mbsp_out_reg.sv -----
// ----------------------------------------------------------------------------
// mbsp_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbsp_pkg::result_t res,
	input  wire logic              load,
	output logic                   can_load,
	mbsp_out_if.source             out_word
);

	logic valid_q;

	assign can_load       = !valid_q || out_word.ready;
	assign out_word.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_word.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word.kind        <= res.kind;
			out_word.status_byte <= res.status_byte;
			out_word.first_data  <= res.first_data;
			out_word.second_data <= res.second_data;
			out_word.sysex_byte  <= res.sysex_byte;
			out_word.chunk_last  <= res.chunk_last;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
